>>> hw/rtl/hmp_pkg.sv
// Shared types and constants for the MAC address text parser.
package hmp_pkg;

  localparam int NUM_FIELDS_DEF = 6;
  localparam int MAC_W          = 48;
  localparam int CNT_W          = 3;
  localparam int CHAR_W         = 8;
  localparam int BYTE_W         = 8;
  localparam int DIGIT_W        = 4;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAR_W-1:0] CH_PCT     = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] CH_THREE   = 8'h33;  // '3'
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;  // 'F'
  localparam logic [DIGIT_W-1:0] LETTER_BASE = 4'd10;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // Classified character, as handed from front to back
  typedef struct packed {
    logic               first;
    logic               is_hex;
    logic [DIGIT_W-1:0] digit;
    logic               is_pct;
    logic               is_three;
    logic               is_upper_a;
  } hmp_class_t;

  typedef struct packed {
    logic [MAC_W-1:0] mac_address;
    logic             status;
    logic [CNT_W-1:0] field_count;
  } hmp_result_t;

  typedef enum logic [4:0] {
    PH_HALT  = 5'b00001,
    PH_START = 5'b00010,
    PH_FIELD = 5'b00100,
    PH_PCT   = 5'b01000,
    PH_PCT3  = 5'b10000
  } hmp_phase_t;

endpackage

>>> hw/rtl/hmp_front.sv
// Front end: accepts characters and classifies them for the parser.
module hmp_front (
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // char_code
  input  logic [0:0]               s_axis_tuser,   // first
  input  logic                     q_full,
  output logic                     push,
  output hmp_pkg::hmp_class_t      push_data
);
  import hmp_pkg::*;

  logic [CHAR_W-1:0] c;
  logic              is_dec;
  logic              is_low;
  logic              is_up;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  assign is_dec = (c >= CH_ZERO)    && (c <= CH_NINE);
  assign is_low = (c >= CH_LOWER_A) && (c <= CH_LOWER_F);
  assign is_up  = (c >= CH_UPPER_A) && (c <= CH_UPPER_F);

  always_comb begin
    push_data.first      = s_axis_tuser[0];
    push_data.is_hex     = is_dec || is_low || is_up;
    // letters differ only in the low nibble, 'a'/'A' = 1
    if (is_dec) begin
      push_data.digit = c[DIGIT_W-1:0];
    end else begin
      push_data.digit = c[DIGIT_W-1:0] + LETTER_BASE - 4'd1;
    end
    push_data.is_pct     = (c == CH_PCT);
    push_data.is_three   = (c == CH_THREE);
    push_data.is_upper_a = (c == CH_UPPER_A);
  end

endmodule

>>> hw/rtl/hmp_queue.sv
// Short queue of classified characters between front and back.
module hmp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hmp_pkg::hmp_class_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output hmp_pkg::hmp_class_t pop_data
);
  import hmp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  hmp_class_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_QW-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_QW'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_QW'(1);
        2'b01:   count <= count - CNT_QW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/hmp_back.sv
// Back end: field parser state machine and result output register.
module hmp_back #(
  parameter int NUM_FIELDS = hmp_pkg::NUM_FIELDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  hmp_pkg::hmp_class_t  item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hmp_pkg::hmp_result_t out_res
);
  import hmp_pkg::*;

  localparam int IDX_W  = $clog2(NUM_FIELDS + 1);
  localparam int CAT_W  = NUM_FIELDS * BYTE_W;
  localparam int WIDE_W = (CAT_W > MAC_W) ? CAT_W : MAC_W;

  hmp_phase_t        phase, phase_eff, phase_next;
  logic [BYTE_W-1:0] value, value_eff, value_next;
  logic [IDX_W-1:0]  index, index_eff, index_next;
  logic [BYTE_W-1:0] bytes      [NUM_FIELDS];
  logic [BYTE_W-1:0] bytes_eff  [NUM_FIELDS];
  logic [BYTE_W-1:0] bytes_next [NUM_FIELDS];

  logic                emit;
  logic                ovf;
  logic                step;
  logic [WIDE_W-1:0]   wide;
  logic [IDX_W+2:0]    count_ext;
  hmp_result_t         res;

  assign step = q_valid && (!out_valid || out_ready);
  assign pop  = step;

  always_comb begin
    phase_eff = item.first ? PH_START : phase;
    value_eff = item.first ? '0 : value;
    index_eff = item.first ? '0 : index;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      bytes_eff[k] = item.first ? '0 : bytes[k];
    end

    phase_next = phase_eff;
    value_next = value_eff;
    index_next = index_eff;
    bytes_next = bytes_eff;
    emit       = 1'b0;
    ovf        = 1'b0;

    unique case (phase_eff)
      PH_START, PH_FIELD: begin
        if (item.is_hex) begin
          // value*16+digit exceeds 255 once the high nibble is set
          if (value_eff[BYTE_W-1 -: DIGIT_W] != '0) begin
            emit = 1'b1;
            ovf  = 1'b1;
          end else begin
            value_next = {value_eff[DIGIT_W-1:0], item.digit};
            phase_next = PH_FIELD;
          end
        end else if (phase_eff == PH_START) begin
          if (item.is_pct) begin
            phase_next = PH_PCT;
          end else begin
            emit = 1'b1;
          end
        end else begin
          // close the open field
          for (int k = 0; k < NUM_FIELDS; k++) begin
            if (index_eff == IDX_W'(k)) begin
              bytes_next[k] = value_eff;
            end
          end
          index_next = index_eff + IDX_W'(1);
          value_next = '0;
          if (index_next >= IDX_W'(NUM_FIELDS)) begin
            emit = 1'b1;
          end else if (item.is_pct) begin
            phase_next = PH_PCT;
          end else begin
            emit = 1'b1;
          end
        end
      end
      PH_PCT: begin
        if (item.is_three) begin
          phase_next = PH_PCT3;
        end else begin
          emit = 1'b1;
        end
      end
      PH_PCT3: begin
        if (item.is_upper_a) begin
          value_next = '0;
          phase_next = PH_FIELD;
        end else begin
          emit = 1'b1;
        end
      end
      PH_HALT: begin
      end
      default: phase_next = PH_HALT;
    endcase

    if (emit) begin
      phase_next = PH_HALT;
    end
  end

  // first field lands in the most significant byte
  always_comb begin
    wide = '0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      wide[(NUM_FIELDS-1-k)*BYTE_W +: BYTE_W] = bytes_next[k];
    end
    count_ext           = {3'b000, index_next};
    res.mac_address     = ovf ? '0 : wide[MAC_W-1:0];
    res.status          = ovf ? STATUS_OVERFLOW : STATUS_OK;
    res.field_count     = count_ext[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HALT;
      value <= '0;
      index <= '0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        bytes[k] <= '0;
      end
    end else if (step) begin
      phase <= phase_next;
      value <= value_next;
      index <= index_next;
      bytes <= bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res <= res;
    end
  end

`ifndef SYNTHESIS
  a_ovf_zero_mac: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == STATUS_OVERFLOW) |-> (out_res.mac_address == '0))
    else $error("overflow result carries a nonzero address");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    index <= IDX_W'(NUM_FIELDS))
    else $error("field index past the field count");

  a_emit_halts: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |=> (phase == PH_HALT && out_valid))
    else $error("parser did not halt after emitting a result");
`endif

endmodule

>>> hw/rtl/hex_mac_address_parser.sv
// Top level of the MAC address text parser.
//
// Characters of a MAC address text enter on the s_axis channel, one per
// transaction; tuser marks the first character of a new string, which
// restarts the parse. Hex digits in either case form fields, "%3A" separates
// them. At most one result per string leaves on m_axis: six bytes (first
// field on top), a field count and an overflow flag in tuser.
// Throughput: one character per cycle while no result waits on a stalled m_axis.
// Latency: the result is valid the cycle after the parser takes the character
// that ends the parse; a character is registered in the two-entry queue
// between the classifier and the parser before the parser sees it.
// Reset clears the queue, the output valid flag and the parser, which then
// ignores characters until one arrives flagged as first.
// When m_axis stalls with a result waiting, the parser holds; the queue fills
// and s_axis_tready drops once it is full.
module hex_mac_address_parser #(
  parameter int NUM_FIELDS = hmp_pkg::NUM_FIELDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]  s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [47:0] mac_address, [50:48] field_count, rest zero
  output logic [0:0]  m_axis_tuser    // [0] status
);
  import hmp_pkg::*;

  hmp_class_t  push_data;
  hmp_class_t  pop_data;
  hmp_result_t res;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;

  hmp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  hmp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  hmp_back #(
    .NUM_FIELDS (NUM_FIELDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .item      (pop_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {5'b00000, res.field_count, res.mac_address};
  assign m_axis_tuser = res.status;

endmodule
